@@ sv/mrm_pkg.sv @@
// Package: shared types, codes and the CRC step for the Modbus RTU master.
package mrm_pkg;

  localparam int RX_DEPTH_DEF = 16;
  localparam int WORD_LIMIT   = 10;

  localparam logic [7:0]  FN_WRITE_MULTI = 8'h10;
  localparam logic [7:0]  FN_READ_HOLD   = 8'h03;
  localparam logic [15:0] WRITE_ECHO_CNT = 16'h0001;
  localparam logic [7:0]  WRITE_BYTE_CNT = 8'h02;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [3:0]  WRITE_LEN      = 4'd11;
  localparam logic [3:0]  READ_LEN       = 4'd8;
  localparam logic [3:0]  WRITE_MIN_RX   = 4'd8;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_BYTE  = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_WORD   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_PARAM = 3'd1,
    STAT_TIMEOUT   = 3'd2,
    STAT_MISMATCH  = 3'd3,
    STAT_CRC       = 3'd4,
    STAT_EXCEPTION = 3'd5,
    STAT_BUSY      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    CFG_MAX_ADDR  = 3'd0,
    CFG_IDLE_GAP  = 3'd1,
    CFG_WR_TMO    = 3'd2,
    CFG_RD_TMO    = 3'd3,
    CFG_CHECK_WR  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TX,
    ST_STAT,
    ST_RDHI,
    ST_RDLO,
    ST_WORD
  } state_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ sv/mrm_chan_if.sv @@
// Interfaces: request channel and result channel with valid/ready handshake.
interface mrm_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic        [7:0]  dev_address;
  logic        [15:0] reg_address;
  logic signed [15:0] write_value;
  logic        [6:0]  word_count;
  logic        [7:0]  rx_byte;

  modport source (output valid, action, dev_address, reg_address, write_value, word_count,
                  rx_byte, input ready);
  modport sink   (input valid, action, dev_address, reg_address, write_value, word_count,
                  rx_byte, output ready);
endinterface

interface mrm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [15:0] data_word;
  logic [2:0]  status;
  logic [7:0]  exception_code;
  logic        last;

  modport source (output valid, kind, tx_byte, data_word, status, exception_code, last,
                  input ready);
  modport sink   (input valid, kind, tx_byte, data_word, status, exception_code, last,
                  output ready);
endinterface

@@ sv/mrm_ram.sv @@
// Generic single-port RAM with registered read.
module mrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ sv/modbus_rtu_master_transaction.sv @@
// Top level: Modbus RTU master transaction engine.
// Usage:
//   in_ch carries one action per beat: write request, read request, received
//   line byte, or one timer tick. out_ch carries result beats: frame bytes to
//   transmit, a transaction status, and data words of a good read; the final
//   beat caused by an action has last set. cfg_we/cfg_idx/cfg_wdata write the
//   five setup registers; the user must do so only while the block is idle,
//   which the block does not enforce. A request sends its frame bytes (8 or 11
//   beats); the shared CRC unit folds one byte per cycle while out_ch does not
//   stall. A tick that closes the frame moves the sequencer to the status state,
//   which registers the status beat; each data word then goes through the RDHI,
//   RDLO and WORD states and the registered read port of the receive store.
//   The response CRC is folded as bytes arrive, so no pass over the store runs.
//   Reset returns setup registers to their defaults and the engine to idle.
//   When out_ch stalls, the result register holds its beat and the sequencer
//   waits; in_ch is ready only while the sequencer is idle.
module modbus_rtu_master_transaction #(
  parameter int RX_DEPTH = mrm_pkg::RX_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  mrm_in_if.sink                  in_ch,
  mrm_out_if.source               out_ch,
  input  logic                    cfg_we,
  input  mrm_pkg::cfg_idx_t       cfg_idx,
  input  logic [7:0]              cfg_wdata
);
  import mrm_pkg::*;

  localparam int AW = $clog2(RX_DEPTH);
  localparam int FW = $clog2(RX_DEPTH + 1);

  state_t      state_r, state_nxt;
  logic        busy_r, busy_nxt;
  logic        pend_read_r, pend_read_nxt;
  logic [7:0]  exp_addr_r, exp_addr_nxt;
  logic [15:0] exp_reg_r, exp_reg_nxt;
  logic [6:0]  exp_cnt_r, exp_cnt_nxt;
  logic [15:0] wval_r, wval_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]  silent_r, silent_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  hdr_r [6];
  logic [7:0]  hdr_nxt [6];
  logic [3:0]  idx_r, idx_nxt;
  logic [3:0]  words_r, words_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [7:0]  hi_r, hi_nxt;
  status_t     stat_r, stat_nxt;
  logic [7:0]  exc_r, exc_nxt;

  logic [7:0]  cfg_max_r, cfg_gap_r, cfg_wtmo_r, cfg_rtmo_r;
  logic        cfg_chk_r;

  logic        ov_r, ov_nxt;
  kind_t       okind_r, okind_nxt;
  logic [7:0]  otx_r, otx_nxt;
  logic [15:0] oword_r, oword_nxt;
  status_t     ostat_r, ostat_nxt;
  logic [7:0]  oexc_r, oexc_nxt;
  logic        olast_r, olast_nxt;

  logic        accept, out_free;
  action_t     act;
  logic        bad_req;
  logic [7:0]  sil_inc, limit;
  logic        frame_end;
  status_t     judge_stat;
  logic [7:0]  judge_exc;
  logic [3:0]  judge_words;
  logic        crc_ok;
  logic [3:0]  tx_len;
  logic [7:0]  tx_cur;
  logic [7:0]  crc_b;
  logic [15:0] crc_out;
  logic [AW-1:0] rd_addr_inc;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]  ram_rdata;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && (state_r == ST_IDLE);
  assign act         = action_t'(in_ch.action);
  assign out_free    = !ov_r || out_ch.ready;

  assign out_ch.valid          = ov_r;
  assign out_ch.kind           = okind_r;
  assign out_ch.tx_byte        = otx_r;
  assign out_ch.data_word      = oword_r;
  assign out_ch.status         = ostat_r;
  assign out_ch.exception_code = oexc_r;
  assign out_ch.last           = olast_r;

  // shared CRC unit
  assign crc_b   = (state_r == ST_TX) ? tx_cur : in_ch.rx_byte;
  assign crc_out = crc_byte(crc_r, crc_b);

  assign tx_len = pend_read_r ? READ_LEN : WRITE_LEN;

  always_comb begin
    tx_cur = 8'h00;
    case (idx_r)
      4'd0: tx_cur = exp_addr_r;
      4'd1: tx_cur = pend_read_r ? FN_READ_HOLD : FN_WRITE_MULTI;
      4'd2: tx_cur = exp_reg_r[15:8];
      4'd3: tx_cur = exp_reg_r[7:0];
      4'd4: tx_cur = 8'h00;
      4'd5: tx_cur = pend_read_r ? {1'b0, exp_cnt_r} : WRITE_ECHO_CNT[7:0];
      4'd6: tx_cur = pend_read_r ? crc_r[7:0] : WRITE_BYTE_CNT;
      4'd7: tx_cur = pend_read_r ? crc_r[15:8] : wval_r[15:8];
      4'd8: tx_cur = wval_r[7:0];
      4'd9: tx_cur = crc_r[7:0];
      4'd10: tx_cur = crc_r[15:8];
      default: tx_cur = 8'h00;
    endcase
  end

  assign bad_req = (in_ch.dev_address == 8'd0) || (in_ch.dev_address > cfg_max_r) ||
                   ((act == ACT_READ) && (in_ch.word_count == 7'd0));

  assign sil_inc   = (silent_r == 8'hFF) ? silent_r : silent_r + 8'd1;
  assign limit     = pend_read_r ? cfg_rtmo_r : cfg_wtmo_r;
  assign frame_end = (sil_inc >= limit) || ((fill_r != '0) && (sil_inc > cfg_gap_r));
  assign crc_ok    = (fill_r >= FW'(2)) && (crc_r == 16'h0000);

  always_comb begin
    judge_stat  = STAT_OK;
    judge_exc   = 8'h00;
    judge_words = 4'd0;
    if (!pend_read_r) begin
      if (fill_r < FW'(WRITE_MIN_RX)) begin
        judge_stat = STAT_TIMEOUT;
      end else if (cfg_chk_r && (hdr_r[0] != exp_addr_r)) begin
        judge_stat = STAT_MISMATCH;
      end else if (cfg_chk_r && !crc_ok) begin
        judge_stat = STAT_CRC;
      end else if (hdr_r[1][7]) begin
        judge_stat = STAT_EXCEPTION;
        judge_exc  = hdr_r[2];
      end else if ((hdr_r[1] != FN_WRITE_MULTI) || ({hdr_r[2], hdr_r[3]} != exp_reg_r) ||
                   ({hdr_r[4], hdr_r[5]} != WRITE_ECHO_CNT)) begin
        judge_stat = STAT_MISMATCH;
      end
    end else begin
      if (10'(fill_r) < (10'd5 + 10'({exp_cnt_r, 1'b0}))) begin
        judge_stat = STAT_TIMEOUT;
      end else if (hdr_r[0] != exp_addr_r) begin
        judge_stat = STAT_MISMATCH;
      end else if (!crc_ok) begin
        judge_stat = STAT_CRC;
      end else if (hdr_r[1][7]) begin
        judge_stat = STAT_EXCEPTION;
        judge_exc  = hdr_r[2];
      end else if ((hdr_r[1] != FN_READ_HOLD) || (hdr_r[2] != {exp_cnt_r, 1'b0})) begin
        judge_stat = STAT_MISMATCH;
      end else begin
        judge_words = (exp_cnt_r > 7'(WORD_LIMIT)) ? 4'(WORD_LIMIT) : exp_cnt_r[3:0];
      end
    end
  end

  assign rd_addr_inc = (rd_addr_r == AW'(RX_DEPTH - 1)) ? '0 : rd_addr_r + AW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_WRITE, ACT_READ: state_nxt = (busy_r || bad_req) ? ST_STAT : ST_TX;
            ACT_TICK: if (busy_r && frame_end) state_nxt = ST_STAT;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TX: if (out_free && (idx_r == tx_len - 4'd1)) state_nxt = ST_IDLE;
      ST_STAT: if (out_free) state_nxt = (words_r != 4'd0) ? ST_RDHI : ST_IDLE;
      ST_RDHI: state_nxt = ST_RDLO;
      ST_RDLO: state_nxt = ST_WORD;
      ST_WORD: if (out_free) state_nxt = (idx_r == words_r - 4'd1) ? ST_IDLE : ST_RDHI;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    busy_nxt      = busy_r;
    pend_read_nxt = pend_read_r;
    exp_addr_nxt  = exp_addr_r;
    exp_reg_nxt   = exp_reg_r;
    exp_cnt_nxt   = exp_cnt_r;
    wval_nxt      = wval_r;
    fill_nxt      = fill_r;
    silent_nxt    = silent_r;
    crc_nxt       = crc_r;
    hdr_nxt       = hdr_r;
    idx_nxt       = idx_r;
    words_nxt     = words_r;
    rd_addr_nxt   = rd_addr_r;
    hi_nxt        = hi_r;
    stat_nxt      = stat_r;
    exc_nxt       = exc_r;
    ram_we        = 1'b0;
    ram_addr      = rd_addr_r;
    ov_nxt        = out_ch.ready ? 1'b0 : ov_r;
    okind_nxt     = okind_r;
    otx_nxt       = otx_r;
    oword_nxt     = oword_r;
    ostat_nxt     = ostat_r;
    oexc_nxt      = oexc_r;
    olast_nxt     = olast_r;
    case (state_r)
      ST_IDLE: begin
        ram_addr = fill_r[AW-1:0];
        if (accept) begin
          case (act)
            ACT_WRITE, ACT_READ: begin
              words_nxt = 4'd0;
              exc_nxt   = 8'h00;
              if (busy_r) begin
                stat_nxt = STAT_BUSY;
              end else if (bad_req) begin
                stat_nxt = STAT_BAD_PARAM;
              end else begin
                busy_nxt      = 1'b1;
                pend_read_nxt = (act == ACT_READ);
                exp_addr_nxt  = in_ch.dev_address;
                exp_reg_nxt   = in_ch.reg_address;
                exp_cnt_nxt   = in_ch.word_count;
                wval_nxt      = in_ch.write_value;
                fill_nxt      = '0;
                silent_nxt    = 8'h00;
                crc_nxt       = CRC_INIT;
                idx_nxt       = 4'd0;
              end
            end
            ACT_BYTE: begin
              if (busy_r) begin
                silent_nxt = 8'h00;
                if (fill_r < FW'(RX_DEPTH)) begin
                  ram_we   = 1'b1;
                  fill_nxt = fill_r + FW'(1);
                  crc_nxt  = crc_out;
                  for (int i = 0; i < 6; i++) begin
                    if (fill_r == FW'(i)) hdr_nxt[i] = in_ch.rx_byte;
                  end
                end
              end
            end
            default: begin
              if (busy_r) begin
                silent_nxt = sil_inc;
                if (frame_end) begin
                  busy_nxt  = 1'b0;
                  stat_nxt  = judge_stat;
                  exc_nxt   = judge_exc;
                  words_nxt = judge_words;
                end
              end
            end
          endcase
        end
      end
      ST_TX: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_TX;
          otx_nxt   = tx_cur;
          oword_nxt = 16'h0000;
          ostat_nxt = STAT_OK;
          oexc_nxt  = 8'h00;
          olast_nxt = (idx_r == tx_len - 4'd1);
          idx_nxt   = idx_r + 4'd1;
          if (idx_r < tx_len - 4'd2) begin
            crc_nxt = crc_out;
          end else if (idx_r == tx_len - 4'd1) begin
            crc_nxt = CRC_INIT;
          end
        end
      end
      ST_STAT: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          okind_nxt   = KIND_STATUS;
          otx_nxt     = 8'h00;
          oword_nxt   = 16'h0000;
          ostat_nxt   = stat_r;
          oexc_nxt    = exc_r;
          olast_nxt   = (words_r == 4'd0);
          idx_nxt     = 4'd0;
          rd_addr_nxt = AW'(3);
        end
      end
      ST_RDHI: rd_addr_nxt = rd_addr_inc;
      ST_RDLO: hi_nxt = ram_rdata;
      ST_WORD: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          okind_nxt   = KIND_WORD;
          otx_nxt     = 8'h00;
          oword_nxt   = {hi_r, ram_rdata};
          ostat_nxt   = STAT_OK;
          oexc_nxt    = 8'h00;
          olast_nxt   = (idx_r == words_r - 4'd1);
          idx_nxt     = idx_r + 4'd1;
          rd_addr_nxt = rd_addr_inc;
        end
      end
      default: ;
    endcase
  end

  mrm_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_ch.rx_byte),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      pend_read_r <= 1'b0;
      fill_r      <= '0;
      silent_r    <= 8'h00;
      ov_r        <= 1'b0;
      cfg_max_r   <= 8'd4;
      cfg_gap_r   <= 8'd2;
      cfg_wtmo_r  <= 8'd5;
      cfg_rtmo_r  <= 8'd100;
      cfg_chk_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      pend_read_r <= pend_read_nxt;
      fill_r      <= fill_nxt;
      silent_r    <= silent_nxt;
      ov_r        <= ov_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MAX_ADDR: cfg_max_r  <= cfg_wdata;
          CFG_IDLE_GAP: cfg_gap_r  <= cfg_wdata;
          CFG_WR_TMO:   cfg_wtmo_r <= cfg_wdata;
          CFG_RD_TMO:   cfg_rtmo_r <= cfg_wdata;
          CFG_CHECK_WR: cfg_chk_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    exp_addr_r <= exp_addr_nxt;
    exp_reg_r  <= exp_reg_nxt;
    exp_cnt_r  <= exp_cnt_nxt;
    wval_r     <= wval_nxt;
    crc_r      <= crc_nxt;
    hdr_r      <= hdr_nxt;
    idx_r      <= idx_nxt;
    words_r    <= words_nxt;
    rd_addr_r  <= rd_addr_nxt;
    hi_r       <= hi_nxt;
    stat_r     <= stat_nxt;
    exc_r      <= exc_nxt;
    okind_r    <= okind_nxt;
    otx_r      <= otx_nxt;
    oword_r    <= oword_nxt;
    ostat_r    <= ostat_nxt;
    oexc_r     <= oexc_nxt;
    olast_r    <= olast_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(RX_DEPTH))
    else $error("receive fill beyond store depth");

  a_tx_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TX) |-> busy_r)
    else $error("frame transmit without pending transaction");

  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (state_r == ST_STAT))
    else $error("transaction closed without status beat");

  a_words_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDHI) |-> (pend_read_r && (words_r != 4'd0) && !busy_r))
    else $error("data word fetch outside a good read");

endmodule

@@ dv/tb_top.sv @@
// Testbench top: drives the Modbus RTU master and checks every result beat against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import mrm_pkg::*;

  typedef struct {
    action_t     action;
    logic [7:0]  dev;
    logic [15:0] reg_a;
    logic [15:0] val;
    logic [6:0]  cnt;
    logic [7:0]  rb;
  } req_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  tx;
    logic [15:0] word;
    status_t     st;
    logic [7:0]  exc;
    logic        last;
  } beat_t;

  typedef enum int {
    RSP_GOOD, RSP_CORRUPT, RSP_SHORT, RSP_LONG, RSP_NONE, RSP_EXC, RSP_BAD_ADDR, RSP_BAD_FN
  } rsp_t;

  class master_scoreboard;
    logic [7:0]  max_addr = 8'd4;
    logic [7:0]  gap = 8'd2;
    logic [7:0]  wr_tmo = 8'd5;
    logic [7:0]  rd_tmo = 8'd100;
    logic        chk_wr = 1'b0;
    logic        busy = 1'b0;
    logic        is_rd = 1'b0;
    logic [7:0]  exp_addr = 8'd0;
    logic [15:0] exp_reg = 16'd0;
    logic [6:0]  exp_cnt = 7'd0;
    logic [7:0]  store [16];
    int          fill = 0;
    logic [7:0]  silent = 8'd0;
    beat_t       batch[$];
    beat_t       pend[$];
    int          errors = 0;

    static function logic [15:0] crc16(input logic [7:0] d[$], input int n);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int i = 0; i < n; i++) begin
        c = c ^ {8'h00, d[i]};
        for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
    endfunction

    function void add(kind_t k, logic [7:0] tx, logic [15:0] w, status_t st, logic [7:0] e);
      beat_t r;
      r.kind = k; r.tx = tx; r.word = w; r.st = st; r.exc = e; r.last = 1'b0;
      batch.push_back(r);
    endfunction

    function void set_cfg(cfg_idx_t idx, logic [7:0] v);
      case (idx)
        CFG_MAX_ADDR: max_addr = v;
        CFG_IDLE_GAP: gap = v;
        CFG_WR_TMO:   wr_tmo = v;
        CFG_RD_TMO:   rd_tmo = v;
        CFG_CHECK_WR: chk_wr = v[0];
        default: ;
      endcase
    endfunction

    function bit crc_good();
      logic [7:0] d[$];
      if (fill < 2) return 0;
      for (int i = 0; i < fill - 2; i++) d.push_back(store[i]);
      return crc16(d, fill - 2) == {store[fill-1], store[fill-2]};
    endfunction

    function void judge();
      int words;
      if (!is_rd) begin
        if (fill < 8) add(KIND_STATUS, 0, 0, STAT_TIMEOUT, 0);
        else if (chk_wr && store[0] != exp_addr) add(KIND_STATUS, 0, 0, STAT_MISMATCH, 0);
        else if (chk_wr && !crc_good()) add(KIND_STATUS, 0, 0, STAT_CRC, 0);
        else if (store[1][7]) add(KIND_STATUS, 0, 0, STAT_EXCEPTION, store[2]);
        else if (store[1] != FN_WRITE_MULTI || {store[2], store[3]} != exp_reg ||
                 {store[4], store[5]} != WRITE_ECHO_CNT)
          add(KIND_STATUS, 0, 0, STAT_MISMATCH, 0);
        else add(KIND_STATUS, 0, 0, STAT_OK, 0);
        return;
      end
      if (fill < 5 + 2 * exp_cnt) add(KIND_STATUS, 0, 0, STAT_TIMEOUT, 0);
      else if (store[0] != exp_addr) add(KIND_STATUS, 0, 0, STAT_MISMATCH, 0);
      else if (!crc_good()) add(KIND_STATUS, 0, 0, STAT_CRC, 0);
      else if (store[1][7]) add(KIND_STATUS, 0, 0, STAT_EXCEPTION, store[2]);
      else if (store[1] != FN_READ_HOLD || store[2] != {exp_cnt, 1'b0})
        add(KIND_STATUS, 0, 0, STAT_MISMATCH, 0);
      else begin
        add(KIND_STATUS, 0, 0, STAT_OK, 0);
        words = (exp_cnt > WORD_LIMIT) ? WORD_LIMIT : exp_cnt;
        for (int i = 0; i < words; i++)
          add(KIND_WORD, 0, {store[(3 + 2 * i) % 16], store[(4 + 2 * i) % 16]}, STAT_OK, 0);
      end
    endfunction

    function void note(req_t it);
      logic [7:0]  fr[$];
      logic [15:0] c;
      logic [7:0]  lim;
      batch.delete();
      case (it.action)
        ACT_WRITE, ACT_READ: begin
          if (busy) add(KIND_STATUS, 0, 0, STAT_BUSY, 0);
          else if (it.dev == 0 || it.dev > max_addr || (it.action == ACT_READ && it.cnt == 0))
            add(KIND_STATUS, 0, 0, STAT_BAD_PARAM, 0);
          else begin
            fr.push_back(it.dev);
            fr.push_back(it.action == ACT_WRITE ? FN_WRITE_MULTI : FN_READ_HOLD);
            fr.push_back(it.reg_a[15:8]);
            fr.push_back(it.reg_a[7:0]);
            if (it.action == ACT_WRITE) begin
              fr.push_back(8'h00); fr.push_back(8'h01); fr.push_back(WRITE_BYTE_CNT);
              fr.push_back(it.val[15:8]); fr.push_back(it.val[7:0]);
            end else begin
              fr.push_back(8'h00); fr.push_back({1'b0, it.cnt});
            end
            c = crc16(fr, fr.size());
            fr.push_back(c[7:0]);
            fr.push_back(c[15:8]);
            foreach (fr[i]) add(KIND_TX, fr[i], 0, STAT_OK, 0);
            busy = 1; is_rd = (it.action == ACT_READ);
            exp_addr = it.dev; exp_reg = it.reg_a; exp_cnt = it.cnt;
            fill = 0; silent = 0;
          end
        end
        ACT_BYTE: if (busy) begin
          if (fill < 16) begin
            store[fill] = it.rb;
            fill++;
          end
          silent = 0;
        end
        default: if (busy) begin
          lim = is_rd ? rd_tmo : wr_tmo;
          if (silent != 8'd255) silent++;
          if (silent >= lim || (fill > 0 && silent > gap)) begin
            judge();
            busy = 0;
          end
        end
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pend.push_back(batch[i]);
    endfunction

    function void check(beat_t got);
      beat_t e;
      if (pend.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", got.kind);
        errors++;
        return;
      end
      e = pend.pop_front();
      if (got.kind != e.kind) begin
        $error("kind expected %0d actual %0d", e.kind, got.kind); errors++;
      end
      if (got.tx !== e.tx) begin
        $error("tx_byte expected %0h actual %0h", e.tx, got.tx); errors++;
      end
      if (got.word !== e.word) begin
        $error("data_word expected %0h actual %0h", e.word, got.word); errors++;
      end
      if (got.st != e.st) begin
        $error("status expected %0d actual %0d", e.st, got.st); errors++;
      end
      if (got.exc !== e.exc) begin
        $error("exception_code expected %0h actual %0h", e.exc, got.exc); errors++;
      end
      if (got.last !== e.last) begin
        $error("last expected %0d actual %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           cfg_we;
  cfg_idx_t       cfg_idx;
  logic [7:0]     cfg_wdata;
  bit             idle_on = 1'b1;
  bit             hold_req = 1'b0;
  int             n_items = 0;
  master_scoreboard model = new();

  mrm_in_if  in_ch();
  mrm_out_if out_ch();

  modbus_rtu_master_transaction i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    beat_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.kind = kind_t'(out_ch.kind); r.tx = out_ch.tx_byte; r.word = out_ch.data_word;
      r.st = status_t'(out_ch.status); r.exc = out_ch.exception_code; r.last = out_ch.last;
      model.check(r);
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic req_t rand_req();
    req_t it;
    it.action = action_t'($urandom_range(0, 3));
    it.dev = 8'($urandom); it.reg_a = 16'($urandom); it.val = 16'($urandom);
    it.cnt = 7'($urandom); it.rb = 8'($urandom);
    return it;
  endfunction

  task automatic send(req_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= it.action; in_ch.dev_address <= it.dev; in_ch.reg_address <= it.reg_a;
    in_ch.write_value <= it.val; in_ch.word_count <= it.cnt; in_ch.rx_byte <= it.rb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    model.note(it);
    n_items++;
  endtask

  task automatic send_kind(action_t a);
    req_t it;
    it = rand_req();
    it.action = a;
    send(it);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [7:0] v);
    in_ch.valid <= 1'b0;
    while (model.pend.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model.set_cfg(idx, v);
  endtask

  task automatic set_all(logic [7:0] ma, logic [7:0] g, logic [7:0] wt, logic [7:0] rt,
                         logic ck);
    set_reg(CFG_MAX_ADDR, ma);
    set_reg(CFG_IDLE_GAP, g);
    set_reg(CFG_WR_TMO, wt);
    set_reg(CFG_RD_TMO, rt);
    set_reg(CFG_CHECK_WR, {7'd0, ck});
  endtask

  task automatic run_txn(bit rd, logic [7:0] dev, logic [6:0] cnt, rsp_t mode, bit collide);
    req_t        it;
    logic [7:0]  q[$];
    logic [15:0] c;
    int          k;
    it = rand_req();
    it.action = rd ? ACT_READ : ACT_WRITE;
    it.dev = dev; it.cnt = cnt;
    send(it);
    if (!model.busy) return;
    if (collide) send_kind(action_t'($urandom_range(0, 1)));
    if (mode == RSP_EXC) begin
      q.push_back(dev); q.push_back((rd ? FN_READ_HOLD : FN_WRITE_MULTI) | 8'h80);
      q.push_back(8'($urandom));
    end else if (!rd) begin
      q.push_back(dev); q.push_back(FN_WRITE_MULTI);
      q.push_back(it.reg_a[15:8]); q.push_back(it.reg_a[7:0]);
      q.push_back(8'h00); q.push_back(8'h01);
    end else begin
      q.push_back(dev); q.push_back(FN_READ_HOLD); q.push_back({cnt, 1'b0});
      for (int i = 0; i < 2 * cnt && i < 40; i++) q.push_back(8'($urandom));
    end
    if (mode == RSP_BAD_ADDR) q[0] = q[0] + 8'd1;
    if (mode == RSP_BAD_FN) q[1] = q[1] ^ (8'h01 << $urandom_range(0, 6));
    c = master_scoreboard::crc16(q, q.size());
    q.push_back(c[7:0]); q.push_back(c[15:8]);
    case (mode)
      RSP_CORRUPT: begin
        k = $urandom_range(0, q.size() - 1);
        q[k] = q[k] ^ (8'h01 << $urandom_range(0, 7));
      end
      RSP_SHORT: repeat ($urandom_range(1, q.size() - 1)) void'(q.pop_back());
      RSP_LONG:  repeat ($urandom_range(1, 10)) q.push_back(8'($urandom));
      RSP_NONE:  q.delete();
      default: ;
    endcase
    foreach (q[i]) begin
      it = rand_req();
      it.action = ACT_BYTE; it.rb = q[i];
      send(it);
      if (model.gap >= 2 && model.wr_tmo >= 2 && model.rd_tmo >= 2 &&
          $urandom_range(0, 7) == 0)
        send_kind(ACT_TICK);
    end
    while (model.busy) send_kind(ACT_TICK);
  endtask

  task automatic rand_txn();
    rsp_t        mode;
    logic [7:0]  dev;
    logic [6:0]  cnt;
    int          p;
    p = $urandom_range(0, 99);
    if (p < 45) mode = RSP_GOOD;
    else mode = rsp_t'($urandom_range(RSP_CORRUPT, RSP_BAD_FN));
    dev = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, model.max_addr));
    cnt = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 5));
    if ($urandom_range(0, 9) == 0) begin
      send(rand_req());
      while (model.busy) send_kind(ACT_TICK);
    end else begin
      run_txn($urandom_range(0, 1) == 1, dev, cnt, mode, $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    int base;
    cfg_we <= 1'b0; cfg_idx <= CFG_MAX_ADDR; cfg_wdata <= 8'd0;
    in_ch.valid <= 1'b0; in_ch.action <= ACT_TICK; in_ch.dev_address <= 8'd0;
    in_ch.reg_address <= 16'd0; in_ch.write_value <= 16'd0; in_ch.word_count <= 7'd0;
    in_ch.rx_byte <= 8'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults
    send_kind(ACT_BYTE);
    send_kind(ACT_TICK);
    run_txn(0, 8'd1, 7'd1, RSP_GOOD, 0);
    run_txn(1, 8'd4, 7'd1, RSP_GOOD, 0);
    run_txn(1, 8'd0, 7'd3, RSP_GOOD, 0);
    run_txn(0, 8'd5, 7'd3, RSP_GOOD, 0);
    run_txn(1, 8'd2, 7'd0, RSP_GOOD, 0);
    run_txn(1, 8'd3, 7'd5, RSP_GOOD, 1);
    run_txn(0, 8'd2, 7'd1, RSP_EXC, 0);
    run_txn(1, 8'd2, 7'd2, RSP_EXC, 0);
    run_txn(0, 8'd1, 7'd1, RSP_NONE, 0);
    run_txn(1, 8'd1, 7'd2, RSP_LONG, 0);
    run_txn(1, 8'd1, 7'd127, RSP_GOOD, 0);
    run_txn(1, 8'd1, 7'd2, RSP_CORRUPT, 0);
    run_txn(0, 8'd1, 7'd1, RSP_CORRUPT, 0);
    run_txn(0, 8'd1, 7'd1, RSP_BAD_FN, 0);

    // back-pressure: hold the receiver while requests keep coming
    hold_req = 1'b1;
    run_txn(0, 8'd3, 7'd1, RSP_GOOD, 1);
    run_txn(1, 8'd3, 7'd4, RSP_GOOD, 0);

    set_all(8'd247, 8'd1, 8'd1, 8'd1, 1'b1);
    run_txn(0, 8'd247, 7'd1, RSP_GOOD, 0);
    run_txn(0, 8'd248, 7'd1, RSP_GOOD, 0);
    run_txn(0, 8'd255, 7'd1, RSP_GOOD, 0);
    run_txn(0, 8'd9, 7'd1, RSP_BAD_ADDR, 0);
    run_txn(0, 8'd9, 7'd1, RSP_CORRUPT, 0);
    run_txn(1, 8'd100, 7'd5, RSP_BAD_ADDR, 0);
    run_txn(0, 8'd7, 7'd1, RSP_NONE, 0);

    set_all(8'd1, 8'd20, 8'd20, 8'd20, 1'b0);
    run_txn(0, 8'd1, 7'd1, RSP_GOOD, 0);
    run_txn(1, 8'd1, 7'd3, RSP_NONE, 0);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) idle_on = 1'b0;
      set_all(8'($urandom_range(1, 247)), 8'($urandom_range(1, 4)),
              8'($urandom_range(2, 12)), 8'($urandom_range(2, 12)),
              1'($urandom_range(0, 1)));
      base = n_items;
      while (n_items < base + ((ph == 4) ? 30 : 10)) rand_txn();
    end

    in_ch.valid <= 1'b0;
    while (model.pend.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (model.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
sv/mrm_pkg.sv
sv/mrm_chan_if.sv
sv/mrm_ram.sv
sv/modbus_rtu_master_transaction.sv
dv/tb_top.sv
